// File: hw/rtl/lfk_pkg.sv
package lfk_pkg;

	// lanes: hip, thigh, thigh plus knee
	localparam int NUM_LANES  = 3;
	localparam int LANE_HIP   = 0;
	localparam int LANE_THIGH = 1;
	localparam int LANE_KNEE  = 2;

	localparam int ANG_IN_W   = 20;
	localparam int OUT_W      = 19;
	localparam int LEN_W      = 8;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int OUT_FRAC_BITS_DEF = 8;

	// fixed-point formats
	localparam int Q_ANG  = 30;
	localparam int Q_R    = 20;
	localparam int ANG_W  = 38;
	localparam int RED_W  = 34;
	localparam int XY_W   = 33;
	localparam int CS_W   = 32;

	localparam longint PI_Q30          = 64'sd3373259798;
	localparam longint TWO_PI_Q30      = 64'sd6746519596;
	localparam longint HALF_PI_Q30     = 64'sd1686629899;
	localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

	// radians Q.16 to Q.30
	localparam int RAD_SHIFT = 14;

	// degrees Q.8 to radians Q.30: round(|a| * 71 * 2^20 / 1017)
	localparam int     DEG_MUL   = 71;
	localparam int     DEG_DIV   = 1017;
	localparam int     DEG_RND   = 508;
	localparam int     MAG_W     = 26;
	localparam int     QM_W      = 16;
	localparam int     REM_W     = 10;
	localparam int     Q2_W      = 20;
	localparam longint RECIP1    = 64'sd135141548;
	localparam int     RECIP1_W  = 28;
	localparam int     RECIP1_SH = 37;
	localparam longint RECIP2    = 64'sd1081132378;
	localparam int     RECIP2_W  = 31;
	localparam int     RECIP2_SH = 40;

	// turn estimate for the wrap into [-pi, pi)
	localparam int N_W        = ANG_W + 1;
	localparam int EST_SH     = 28;
	localparam int EST_RECIP  = 2608;
	localparam int EST_RSH    = 16;
	localparam int HI_W       = N_W - EST_SH;
	localparam int EP_W       = HI_W + 13;
	localparam int QE_W       = EP_W - EST_RSH;
	localparam int REM_RW     = 36;

	localparam logic [LEN_W-1:0] HIP_LEN_RST   = 8'd11;
	localparam logic [LEN_W-1:0] THIGH_LEN_RST = 8'd54;
	localparam logic [LEN_W-1:0] SHANK_LEN_RST = 8'd72;
	localparam logic             UNITS_RST     = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HIP_LEN     = 4'd0,
		REG_THIGH_LEN   = 4'd1,
		REG_SHANK_LEN   = 4'd2,
		REG_ANGLE_UNITS = 4'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [XY_W-1:0] z;
		logic                   neg;
	} red_t;

	typedef struct packed {
		logic signed [XY_W-1:0] c;
		logic signed [XY_W-1:0] s;
		logic                   neg;
	} sincos_t;

	function automatic logic signed [XY_W-1:0] atan_q30(input int idx);
		case (idx)
			0:       return XY_W'(843314856);
			1:       return XY_W'(497837829);
			2:       return XY_W'(263043836);
			3:       return XY_W'(133525158);
			4:       return XY_W'(67021686);
			5:       return XY_W'(33543515);
			6:       return XY_W'(16775850);
			7:       return XY_W'(8388437);
			8:       return XY_W'(4194282);
			9:       return XY_W'(2097149);
			10:      return XY_W'(1048575);
			11:      return XY_W'(524287);
			12:      return XY_W'(262143);
			13:      return XY_W'(131071);
			14:      return XY_W'(65535);
			15:      return XY_W'(32767);
			16:      return XY_W'(16383);
			17:      return XY_W'(8191);
			18:      return XY_W'(4095);
			19:      return XY_W'(2047);
			20:      return XY_W'(1023);
			21:      return XY_W'(511);
			22:      return XY_W'(255);
			23:      return XY_W'(127);
			default: return '0;
		endcase
	endfunction

endpackage

// File: hw/rtl/lfk_angle_conv.sv
module lfk_angle_conv (
	input  logic clk,
	input  logic arst_n,
	input  logic units,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [lfk_pkg::ANG_IN_W-1:0] ang [lfk_pkg::NUM_LANES],
	output logic out_valid,
	input  logic out_ready,
	output logic signed [lfk_pkg::ANG_W-1:0] rad [lfk_pkg::NUM_LANES]
);

	localparam int NST   = 5;
	localparam int L     = lfk_pkg::NUM_LANES;
	localparam int IW    = lfk_pkg::ANG_IN_W;
	localparam int MW    = lfk_pkg::MAG_W;
	localparam int P1_W  = MW + lfk_pkg::RECIP1_W;
	localparam int X2_W  = lfk_pkg::REM_W + lfk_pkg::Q2_W;
	localparam int P2_W  = X2_W + lfk_pkg::RECIP2_W;
	localparam int DM_W  = lfk_pkg::QM_W + lfk_pkg::Q2_W;
	localparam int AW    = lfk_pkg::ANG_W;

	logic [NST-1:0] valid_s;
	logic [NST-1:0] adv;

	logic              sign_s1 [L];
	logic [MW-1:0]     m_s1    [L];
	logic signed [IW-1:0] raw_s1 [L];

	logic              sign_s2 [L];
	logic [MW-1:0]     m_s2    [L];
	logic [lfk_pkg::QM_W-1:0] qm_s2 [L];
	logic signed [IW-1:0] raw_s2 [L];

	logic              sign_s3 [L];
	logic [lfk_pkg::REM_W-1:0] rm_s3 [L];
	logic [lfk_pkg::QM_W-1:0]  qm_s3 [L];
	logic signed [IW-1:0] raw_s3 [L];

	logic              sign_s4 [L];
	logic [lfk_pkg::Q2_W-1:0] q2_s4 [L];
	logic [lfk_pkg::QM_W-1:0] qm_s4 [L];
	logic signed [IW-1:0] raw_s4 [L];

	logic signed [AW-1:0] rad_s5 [L];

	logic [MW-1:0]           m_nxt   [L];
	logic [lfk_pkg::QM_W-1:0] qm_nxt [L];
	logic [lfk_pkg::REM_W-1:0] rm_nxt [L];
	logic [lfk_pkg::Q2_W-1:0] q2_nxt [L];
	logic signed [AW-1:0]    sel     [L];

	always_comb begin
		adv[NST-1] = !valid_s[NST-1] || out_ready;
		for (int i = NST - 2; i >= 0; i--) begin
			adv[i] = !valid_s[i] || adv[i+1];
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = valid_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			for (int i = 0; i < NST; i++) begin
				if (adv[i]) begin
					valid_s[i] <= (i == 0) ? in_valid : valid_s[i-1];
				end
			end
		end
	end

	always_comb begin
		logic [IW-1:0]     absv;
		logic [P1_W-1:0]   p1;
		logic [MW-1:0]     back;
		logic [X2_W-1:0]   x2;
		logic [P2_W-1:0]   p2;
		logic [DM_W-1:0]   mag;
		logic signed [AW-1:0] degv;
		logic signed [AW-1:0] radv;
		for (int l = 0; l < L; l++) begin
			absv      = ang[l][IW-1] ? (~ang[l] + 1'b1) : ang[l];
			m_nxt[l]  = MW'({{(MW-IW){1'b0}}, absv} * MW'(lfk_pkg::DEG_MUL));

			p1        = {{(P1_W-MW){1'b0}}, m_s1[l]} * P1_W'(lfk_pkg::RECIP1);
			qm_nxt[l] = p1[lfk_pkg::RECIP1_SH +: lfk_pkg::QM_W];

			back      = MW'({{(MW-lfk_pkg::QM_W){1'b0}}, qm_s2[l]} * MW'(lfk_pkg::DEG_DIV));
			rm_nxt[l] = lfk_pkg::REM_W'(m_s2[l] - back);

			x2        = {rm_s3[l], {lfk_pkg::Q2_W{1'b0}}} + X2_W'(lfk_pkg::DEG_RND);
			p2        = {{(P2_W-X2_W){1'b0}}, x2} * P2_W'(lfk_pkg::RECIP2);
			q2_nxt[l] = p2[lfk_pkg::RECIP2_SH +: lfk_pkg::Q2_W];

			mag       = {qm_s4[l], q2_s4[l]};
			degv      = sign_s4[l] ? -AW'(mag) : AW'(mag);
			radv      = AW'(raw_s4[l]) <<< lfk_pkg::RAD_SHIFT;
			sel[l]    = units ? radv : degv;
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < L; l++) begin
			if (adv[0]) begin
				sign_s1[l] <= ang[l][IW-1];
				m_s1[l]    <= m_nxt[l];
				raw_s1[l]  <= ang[l];
			end
			if (adv[1]) begin
				sign_s2[l] <= sign_s1[l];
				m_s2[l]    <= m_s1[l];
				qm_s2[l]   <= qm_nxt[l];
				raw_s2[l]  <= raw_s1[l];
			end
			if (adv[2]) begin
				sign_s3[l] <= sign_s2[l];
				rm_s3[l]   <= rm_nxt[l];
				qm_s3[l]   <= qm_s2[l];
				raw_s3[l]  <= raw_s2[l];
			end
			if (adv[3]) begin
				sign_s4[l] <= sign_s3[l];
				q2_s4[l]   <= q2_nxt[l];
				qm_s4[l]   <= qm_s3[l];
				raw_s4[l]  <= raw_s3[l];
			end
		end
		if (adv[4]) begin
			rad_s5[lfk_pkg::LANE_HIP]   <= sel[lfk_pkg::LANE_HIP];
			rad_s5[lfk_pkg::LANE_THIGH] <= sel[lfk_pkg::LANE_THIGH];
			// third lane carries the knee angle summed onto the thigh
			rad_s5[lfk_pkg::LANE_KNEE]  <= sel[lfk_pkg::LANE_THIGH] + sel[lfk_pkg::LANE_KNEE];
		end
	end

	assign rad = rad_s5;

endmodule

// File: hw/rtl/lfk_range_reduce.sv
module lfk_range_reduce (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic signed [lfk_pkg::ANG_W-1:0] rad [lfk_pkg::NUM_LANES],
	output logic out_valid,
	input  logic out_ready,
	output lfk_pkg::red_t red [lfk_pkg::NUM_LANES]
);

	localparam int NST = 5;
	localparam int L   = lfk_pkg::NUM_LANES;
	localparam int NW  = lfk_pkg::N_W;
	localparam int RW  = lfk_pkg::REM_RW;
	localparam int ZW  = lfk_pkg::RED_W;
	localparam int XW  = lfk_pkg::XY_W;

	logic [NST-1:0] valid_s;
	logic [NST-1:0] adv;

	logic signed [NW-1:0] n_s1 [L];
	logic signed [NW-1:0] n_s2 [L];
	logic signed [lfk_pkg::QE_W-1:0] qe_s2 [L];
	logic signed [RW-1:0] rem_s3 [L];
	logic signed [ZW-1:0] z_s4 [L];
	logic signed [XW-1:0] z_s5 [L];
	logic                 neg_s5 [L];

	logic signed [lfk_pkg::QE_W-1:0] qe_nxt [L];
	logic signed [RW-1:0] rem_nxt [L];
	logic signed [ZW-1:0] z_nxt   [L];
	logic signed [XW-1:0] zf_nxt  [L];
	logic                 neg_nxt [L];

	always_comb begin
		adv[NST-1] = !valid_s[NST-1] || out_ready;
		for (int i = NST - 2; i >= 0; i--) begin
			adv[i] = !valid_s[i] || adv[i+1];
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = valid_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			for (int i = 0; i < NST; i++) begin
				if (adv[i]) begin
					valid_s[i] <= (i == 0) ? in_valid : valid_s[i-1];
				end
			end
		end
	end

	always_comb begin
		logic signed [lfk_pkg::HI_W-1:0] nh;
		logic signed [lfk_pkg::EP_W-1:0] ep;
		logic signed [NW-1:0] turns;
		logic signed [NW-1:0] remw;
		logic signed [RW-1:0] zw;
		for (int l = 0; l < L; l++) begin
			// estimate turns from the top bits; off by at most one
			nh         = n_s1[l][NW-1:lfk_pkg::EST_SH];
			ep         = lfk_pkg::EP_W'(nh) * lfk_pkg::EP_W'(lfk_pkg::EST_RECIP);
			qe_nxt[l]  = ep[lfk_pkg::EP_W-1:lfk_pkg::EST_RSH];

			turns      = NW'(qe_s2[l]) * NW'(lfk_pkg::TWO_PI_Q30);
			remw       = n_s2[l] - turns;
			rem_nxt[l] = RW'(remw);

			// correct the estimate and move back to [-pi, pi) in one add
			if (rem_s3[l] < 0) begin
				zw = rem_s3[l] + RW'(lfk_pkg::PI_Q30);
			end else if (rem_s3[l] >= RW'(lfk_pkg::TWO_PI_Q30)) begin
				zw = rem_s3[l] - RW'(lfk_pkg::PI_Q30) - RW'(lfk_pkg::TWO_PI_Q30);
			end else begin
				zw = rem_s3[l] - RW'(lfk_pkg::PI_Q30);
			end
			z_nxt[l] = ZW'(zw);

			// fold into the half circle the rotator converges on
			if (z_s4[l] > ZW'(lfk_pkg::HALF_PI_Q30)) begin
				zf_nxt[l]  = XW'(z_s4[l] - ZW'(lfk_pkg::PI_Q30));
				neg_nxt[l] = 1'b1;
			end else if (z_s4[l] < -ZW'(lfk_pkg::HALF_PI_Q30)) begin
				zf_nxt[l]  = XW'(z_s4[l] + ZW'(lfk_pkg::PI_Q30));
				neg_nxt[l] = 1'b1;
			end else begin
				zf_nxt[l]  = XW'(z_s4[l]);
				neg_nxt[l] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < L; l++) begin
			if (adv[0]) begin
				n_s1[l] <= NW'(rad[l]) + NW'(lfk_pkg::PI_Q30);
			end
			if (adv[1]) begin
				n_s2[l]  <= n_s1[l];
				qe_s2[l] <= qe_nxt[l];
			end
			if (adv[2]) begin
				rem_s3[l] <= rem_nxt[l];
			end
			if (adv[3]) begin
				z_s4[l] <= z_nxt[l];
			end
			if (adv[4]) begin
				z_s5[l]   <= zf_nxt[l];
				neg_s5[l] <= neg_nxt[l];
			end
		end
	end

	always_comb begin
		for (int l = 0; l < L; l++) begin
			red[l].z   = z_s5[l];
			red[l].neg = neg_s5[l];
		end
	end

endmodule

// File: hw/rtl/lfk_cordic.sv
module lfk_cordic #(
	parameter int CORDIC_STAGES = lfk_pkg::CORDIC_STAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  lfk_pkg::red_t red [lfk_pkg::NUM_LANES],
	output logic out_valid,
	input  logic out_ready,
	output lfk_pkg::sincos_t sc [lfk_pkg::NUM_LANES]
);

	localparam int NST = CORDIC_STAGES;
	localparam int L   = lfk_pkg::NUM_LANES;
	localparam int XW  = lfk_pkg::XY_W;

	logic [NST-1:0] valid_s;
	logic [NST-1:0] adv;

	logic signed [XW-1:0] x_s   [NST][L];
	logic signed [XW-1:0] y_s   [NST][L];
	logic signed [XW-1:0] z_s   [NST][L];
	logic                 neg_s [NST][L];

	logic signed [XW-1:0] nx   [NST][L];
	logic signed [XW-1:0] ny   [NST][L];
	logic signed [XW-1:0] nz   [NST][L];
	logic                 nneg [NST][L];

	always_comb begin
		adv[NST-1] = !valid_s[NST-1] || out_ready;
		for (int i = NST - 2; i >= 0; i--) begin
			adv[i] = !valid_s[i] || adv[i+1];
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = valid_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			for (int i = 0; i < NST; i++) begin
				if (adv[i]) begin
					valid_s[i] <= (i == 0) ? in_valid : valid_s[i-1];
				end
			end
		end
	end

	for (genvar g = 0; g < NST; g++) begin : g_stage
		for (genvar l = 0; l < L; l++) begin : g_lane
			logic signed [XW-1:0] xi;
			logic signed [XW-1:0] yi;
			logic signed [XW-1:0] zi;
			logic                 ni;
			if (g == 0) begin : g_first
				assign xi = XW'(lfk_pkg::CORDIC_GAIN_Q30);
				assign yi = '0;
				assign zi = red[l].z;
				assign ni = red[l].neg;
			end else begin : g_next
				assign xi = x_s[g-1][l];
				assign yi = y_s[g-1][l];
				assign zi = z_s[g-1][l];
				assign ni = neg_s[g-1][l];
			end
			// rotate toward zero residual angle
			assign nx[g][l]   = zi[XW-1] ? xi + (yi >>> g) : xi - (yi >>> g);
			assign ny[g][l]   = zi[XW-1] ? yi - (xi >>> g) : yi + (xi >>> g);
			assign nz[g][l]   = zi[XW-1] ? zi + lfk_pkg::atan_q30(g) : zi - lfk_pkg::atan_q30(g);
			assign nneg[g][l] = ni;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NST; i++) begin
			if (adv[i]) begin
				for (int l = 0; l < L; l++) begin
					x_s[i][l]   <= nx[i][l];
					y_s[i][l]   <= ny[i][l];
					z_s[i][l]   <= nz[i][l];
					neg_s[i][l] <= nneg[i][l];
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < L; l++) begin
			sc[l].c   = x_s[NST-1][l];
			sc[l].s   = y_s[NST-1][l];
			sc[l].neg = neg_s[NST-1][l];
		end
	end

endmodule

// File: hw/rtl/lfk_combine.sv
module lfk_combine #(
	parameter int OUT_FRAC_BITS = lfk_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [lfk_pkg::LEN_W-1:0] hip_len,
	input  logic [lfk_pkg::LEN_W-1:0] thigh_len,
	input  logic [lfk_pkg::LEN_W-1:0] shank_len,
	input  logic in_valid,
	output logic in_ready,
	input  lfk_pkg::sincos_t sc [lfk_pkg::NUM_LANES],
	output logic out_valid,
	input  logic out_ready,
	output logic signed [lfk_pkg::OUT_W-1:0] foot_x,
	output logic signed [lfk_pkg::OUT_W-1:0] foot_y,
	output logic signed [lfk_pkg::OUT_W-1:0] foot_z
);

	localparam int NST    = 5;
	localparam int CW     = lfk_pkg::CS_W;
	localparam int LW     = lfk_pkg::LEN_W;
	localparam int PW     = CW + LW + 1;
	localparam int RW     = PW + 1;
	localparam int R_SH   = lfk_pkg::Q_ANG - lfk_pkg::Q_R;
	localparam int R20_W  = RW - R_SH;
	localparam int XW     = CW + R20_W;
	localparam int OW     = lfk_pkg::OUT_W;
	localparam int SX     = lfk_pkg::Q_ANG + lfk_pkg::Q_R - OUT_FRAC_BITS;
	localparam int SZ     = lfk_pkg::Q_ANG - OUT_FRAC_BITS;
	localparam longint OUT_MAX = (64'sd1 <<< (OW - 1)) - 1;
	localparam longint OUT_MIN = -(64'sd1 <<< (OW - 1));
	localparam logic signed [XW-1:0] RND_X  = XW'(64'sd1 <<< (SX - 1));
	localparam logic signed [RW-1:0] RND_Z  = RW'(64'sd1 <<< (SZ - 1));
	localparam logic signed [RW-1:0] RND_R  = RW'(64'sd1 <<< (R_SH - 1));

	logic [NST-1:0] valid_s;
	logic [NST-1:0] adv;

	logic signed [CW-1:0] ch_s1, sh_s1, ch_s2, sh_s2, ch_s3, sh_s3;
	logic signed [PW-1:0] pct_s1, pck_s1, pst_s1, psk_s1;
	logic signed [RW-1:0] r_s2, z_s2, z_s3, z_s4;
	logic signed [R20_W-1:0] r20_s3;
	logic signed [XW-1:0] px_s4, py_s4;
	logic signed [OW-1:0] x_s5, y_s5, z_s5;

	logic signed [CW-1:0] c_nxt [lfk_pkg::NUM_LANES];
	logic signed [CW-1:0] s_nxt [lfk_pkg::NUM_LANES];
	logic signed [RW-1:0] r_rnd;
	logic signed [XW-1:0] rx, ry;
	logic signed [RW-1:0] rz;

	function automatic logic signed [OW-1:0] sat(input logic signed [XW-1:0] v);
		if (v > XW'(OUT_MAX)) begin
			return OW'(OUT_MAX);
		end else if (v < XW'(OUT_MIN)) begin
			return OW'(OUT_MIN);
		end else begin
			return OW'(v);
		end
	endfunction

	always_comb begin
		adv[NST-1] = !valid_s[NST-1] || out_ready;
		for (int i = NST - 2; i >= 0; i--) begin
			adv[i] = !valid_s[i] || adv[i+1];
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = valid_s[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			for (int i = 0; i < NST; i++) begin
				if (adv[i]) begin
					valid_s[i] <= (i == 0) ? in_valid : valid_s[i-1];
				end
			end
		end
	end

	always_comb begin
		for (int l = 0; l < lfk_pkg::NUM_LANES; l++) begin
			// undo the half-circle fold
			c_nxt[l] = CW'(sc[l].neg ? -sc[l].c : sc[l].c);
			s_nxt[l] = CW'(sc[l].neg ? -sc[l].s : sc[l].s);
		end
		r_rnd = r_s2 + RND_R;
		rx    = (px_s4 + RND_X) >>> SX;
		ry    = (py_s4 + RND_X) >>> SX;
		rz    = (z_s4 + RND_Z) >>> SZ;
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			ch_s1  <= c_nxt[lfk_pkg::LANE_HIP];
			sh_s1  <= s_nxt[lfk_pkg::LANE_HIP];
			pct_s1 <= PW'($signed({1'b0, thigh_len})) * PW'(c_nxt[lfk_pkg::LANE_THIGH]);
			pck_s1 <= PW'($signed({1'b0, shank_len})) * PW'(c_nxt[lfk_pkg::LANE_KNEE]);
			pst_s1 <= PW'($signed({1'b0, thigh_len})) * PW'(s_nxt[lfk_pkg::LANE_THIGH]);
			psk_s1 <= PW'($signed({1'b0, shank_len})) * PW'(s_nxt[lfk_pkg::LANE_KNEE]);
		end
		if (adv[1]) begin
			ch_s2 <= ch_s1;
			sh_s2 <= sh_s1;
			r_s2  <= RW'({hip_len, {lfk_pkg::Q_ANG{1'b0}}}) + RW'(pct_s1) - RW'(pck_s1);
			z_s2  <= RW'(pst_s1) - RW'(psk_s1);
		end
		if (adv[2]) begin
			ch_s3  <= ch_s2;
			sh_s3  <= sh_s2;
			r20_s3 <= r_rnd[RW-1:R_SH];
			z_s3   <= z_s2;
		end
		if (adv[3]) begin
			px_s4 <= XW'(ch_s3) * XW'(r20_s3);
			py_s4 <= XW'(sh_s3) * XW'(r20_s3);
			z_s4  <= z_s3;
		end
		if (adv[4]) begin
			x_s5 <= sat(rx);
			y_s5 <= sat(ry);
			z_s5 <= sat(XW'(rz));
		end
	end

	assign foot_x = x_s5;
	assign foot_y = y_s5;
	assign foot_z = z_s5;

endmodule

// File: hw/rtl/leg_forward_kinematics_unit.sv
// Channel | Direction | Handshake               | Payload
// cfg     | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
// angle   | in        | angle_valid/angle_ready | hip_angle, thigh_angle, knee_angle
// foot    | out       | foot_valid / foot_ready | foot_x, foot_y, foot_z
//
// One angle triple per cycle while the foot channel is not stalled; the stages are:
// five stages of angle conversion, five of wrap and fold, one per CORDIC rotation,
// five of link products, rounding and saturation.
// Reset clears the valid bits and loads the link lengths and angle units.
// A stalled foot channel holds each stage that is full; empty stages still fill.
module leg_forward_kinematics_unit #(
	parameter int CORDIC_STAGES = lfk_pkg::CORDIC_STAGES_DEF,
	parameter int OUT_FRAC_BITS = lfk_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [lfk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfk_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic angle_valid,
	output logic angle_ready,
	input  logic signed [lfk_pkg::ANG_IN_W-1:0] hip_angle,
	input  logic signed [lfk_pkg::ANG_IN_W-1:0] thigh_angle,
	input  logic signed [lfk_pkg::ANG_IN_W-1:0] knee_angle,
	output logic foot_valid,
	input  logic foot_ready,
	output logic signed [lfk_pkg::OUT_W-1:0] foot_x,
	output logic signed [lfk_pkg::OUT_W-1:0] foot_y,
	output logic signed [lfk_pkg::OUT_W-1:0] foot_z
);

	logic [lfk_pkg::LEN_W-1:0] hip_len_q, thigh_len_q, shank_len_q;
	logic                      units_q;

	logic signed [lfk_pkg::ANG_IN_W-1:0] ang [lfk_pkg::NUM_LANES];
	logic signed [lfk_pkg::ANG_W-1:0]    rad [lfk_pkg::NUM_LANES];
	lfk_pkg::red_t    red [lfk_pkg::NUM_LANES];
	lfk_pkg::sincos_t sc  [lfk_pkg::NUM_LANES];

	logic conv_valid, conv_ready;
	logic red_valid, red_ready;
	logic sc_valid, sc_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hip_len_q   <= lfk_pkg::HIP_LEN_RST;
			thigh_len_q <= lfk_pkg::THIGH_LEN_RST;
			shank_len_q <= lfk_pkg::SHANK_LEN_RST;
			units_q     <= lfk_pkg::UNITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (lfk_pkg::cfg_reg_t'(cfg_index))
				lfk_pkg::REG_HIP_LEN:     hip_len_q   <= cfg_data;
				lfk_pkg::REG_THIGH_LEN:   thigh_len_q <= cfg_data;
				lfk_pkg::REG_SHANK_LEN:   shank_len_q <= cfg_data;
				lfk_pkg::REG_ANGLE_UNITS: units_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign ang[lfk_pkg::LANE_HIP]   = hip_angle;
	assign ang[lfk_pkg::LANE_THIGH] = thigh_angle;
	assign ang[lfk_pkg::LANE_KNEE]  = knee_angle;

	lfk_angle_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.units     (units_q),
		.in_valid  (angle_valid),
		.in_ready  (angle_ready),
		.ang       (ang),
		.out_valid (conv_valid),
		.out_ready (conv_ready),
		.rad       (rad)
	);

	lfk_range_reduce u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (conv_valid),
		.in_ready  (conv_ready),
		.rad       (rad),
		.out_valid (red_valid),
		.out_ready (red_ready),
		.red       (red)
	);

	lfk_cordic #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (red_valid),
		.in_ready  (red_ready),
		.red       (red),
		.out_valid (sc_valid),
		.out_ready (sc_ready),
		.sc        (sc)
	);

	lfk_combine #(
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_combine (
		.clk       (clk),
		.arst_n    (arst_n),
		.hip_len   (hip_len_q),
		.thigh_len (thigh_len_q),
		.shank_len (shank_len_q),
		.in_valid  (sc_valid),
		.in_ready  (sc_ready),
		.sc        (sc),
		.out_valid (foot_valid),
		.out_ready (foot_ready),
		.foot_x    (foot_x),
		.foot_y    (foot_y),
		.foot_z    (foot_z)
	);

endmodule

// File: verif/leg_forward_kinematics_unit_tb.sv
module leg_forward_kinematics_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [lfk_pkg::OUT_W-1:0] x;
		logic signed [lfk_pkg::OUT_W-1:0] y;
		logic signed [lfk_pkg::OUT_W-1:0] z;
	} foot_pos_t;

	typedef struct {
		logic [7:0]  l1, l2, l3;
		logic        units;
		logic signed [lfk_pkg::ANG_IN_W-1:0] h, t, k;
		bit          known;
		foot_pos_t   pos;
	} vec_t;

	localparam int MAX_ANG = 524287;
	localparam int MIN_ANG = -524288;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [lfk_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [lfk_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic angle_valid = 1'b0;
	logic angle_ready;
	logic signed [lfk_pkg::ANG_IN_W-1:0] hip_angle = '0;
	logic signed [lfk_pkg::ANG_IN_W-1:0] thigh_angle = '0;
	logic signed [lfk_pkg::ANG_IN_W-1:0] knee_angle = '0;
	logic foot_valid;
	logic foot_ready = 1'b0;
	logic signed [lfk_pkg::OUT_W-1:0] foot_x, foot_y, foot_z;

	logic [7:0] len_hip = lfk_pkg::HIP_LEN_RST;
	logic [7:0] len_thigh = lfk_pkg::THIGH_LEN_RST;
	logic [7:0] len_shank = lfk_pkg::SHANK_LEN_RST;
	logic       units_rad = lfk_pkg::UNITS_RST;

	foot_pos_t pending_pos[$];
	int        err_cnt = 0;
	bit        quiet = 1'b0;
	int        stall_left = 0;

	longint atan_tab[24] = '{
		843314856, 497837829, 263043836, 133525158, 67021686,
		33543515, 16775850, 8388437, 4194282, 2097149,
		1048575, 524287, 262143, 131071, 65535, 32767,
		16383, 8191, 4095, 2047, 1023, 511, 255, 127
	};

	leg_forward_kinematics_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.angle_valid(angle_valid), .angle_ready(angle_ready),
		.hip_angle(hip_angle), .thigh_angle(thigh_angle), .knee_angle(knee_angle),
		.foot_valid(foot_valid), .foot_ready(foot_ready),
		.foot_x(foot_x), .foot_y(foot_y), .foot_z(foot_z)
	);

	always #10 clk = ~clk;

	function automatic longint angle_q30(logic signed [lfk_pkg::ANG_IN_W-1:0] a);
		longint v, n;
		v = a;
		if (units_rad)
			return v * 16384;
		n = v * 297795584;
		if (n >= 0)
			return (n + 2034) / 4068;
		return -((-n + 2034) / 4068);
	endfunction

	task automatic cordic_sincos(input longint a, output longint c, output longint s);
		longint twopi, n, q, x, y, z, dx, dy;
		bit neg;
		twopi = 2 * lfk_pkg::PI_Q30;
		n = a + lfk_pkg::PI_Q30;
		q = (n >= 0) ? n / twopi : -((-n + twopi - 1) / twopi);
		z = a - q * twopi;
		neg = 1'b0;
		x = lfk_pkg::CORDIC_GAIN_Q30;
		y = 0;
		if (z > lfk_pkg::PI_Q30 / 2) begin
			z -= lfk_pkg::PI_Q30;
			neg = 1'b1;
		end else if (z < -(lfk_pkg::PI_Q30 / 2)) begin
			z += lfk_pkg::PI_Q30;
			neg = 1'b1;
		end
		for (int i = 0; i < lfk_pkg::CORDIC_STAGES_DEF; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= atan_tab[i];
			end else begin
				x += dx;
				y -= dy;
				z += atan_tab[i];
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endtask

	function automatic longint round_down(longint v, int sh);
		return (v + (longint'(1) << (sh - 1))) >>> sh;
	endfunction

	function automatic logic signed [lfk_pkg::OUT_W-1:0] clip(longint v);
		if (v > 262143)
			v = 262143;
		if (v < -262144)
			v = -262144;
		return v[lfk_pkg::OUT_W-1:0];
	endfunction

	task automatic foot_position(input logic signed [lfk_pkg::ANG_IN_W-1:0] h, t, k,
			output foot_pos_t p);
		longint ah, at, ak, ch, sh, ct, st, ck, sk, r, r20, zz;
		ah = angle_q30(h);
		at = angle_q30(t);
		ak = angle_q30(k);
		cordic_sincos(ah, ch, sh);
		cordic_sincos(at, ct, st);
		cordic_sincos(at + ak, ck, sk);
		r = longint'(len_hip) * (longint'(1) << 30) + longint'(len_thigh) * ct
			- longint'(len_shank) * ck;
		r20 = round_down(r, 10);
		zz = longint'(len_thigh) * st - longint'(len_shank) * sk;
		p.x = clip(round_down(ch * r20, 50 - lfk_pkg::OUT_FRAC_BITS_DEF));
		p.y = clip(round_down(sh * r20, 50 - lfk_pkg::OUT_FRAC_BITS_DEF));
		p.z = clip(round_down(zz, 30 - lfk_pkg::OUT_FRAC_BITS_DEF));
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_cnt++;
	endtask

	// the transfer happens at the next rising edge; inputs only move at rising edges
	always @(negedge clk) begin
		if (arst_n && foot_valid && foot_ready) begin
			if (pending_pos.size() == 0)
				report_mismatch("unexpected foot transfer", foot_x, 0);
			else begin
				foot_pos_t e;
				e = pending_pos.pop_front();
				if (foot_x !== e.x) report_mismatch("foot_x", foot_x, e.x);
				if (foot_y !== e.y) report_mismatch("foot_y", foot_y, e.y);
				if (foot_z !== e.z) report_mismatch("foot_z", foot_z, e.z);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || quiet)
			foot_ready <= 1'b1;
		else if (stall_left > 0) begin
			stall_left--;
			foot_ready <= 1'b0;
		end else if ($urandom_range(0, 6) == 0) begin
			stall_left = $urandom_range(1, 7) - 1;
			foot_ready <= 1'b0;
		end else
			foot_ready <= 1'b1;
	end

	task automatic wait_drained();
		while (pending_pos.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// leaves cfg_valid high at the transfer edge; the caller drops it
	task automatic write_reg(input logic [lfk_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		case (idx)
			lfk_pkg::REG_HIP_LEN:     len_hip = val;
			lfk_pkg::REG_THIGH_LEN:   len_thigh = val;
			lfk_pkg::REG_SHANK_LEN:   len_shank = val;
			lfk_pkg::REG_ANGLE_UNITS: units_rad = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_links(input logic [7:0] l1, l2, l3, input logic [7:0] u);
		wait_drained();
		write_reg(lfk_pkg::REG_HIP_LEN, l1);
		write_reg(lfk_pkg::REG_THIGH_LEN, l2);
		write_reg(lfk_pkg::REG_SHANK_LEN, l3);
		write_reg(lfk_pkg::REG_ANGLE_UNITS, u);
		// indexes past the register list must leave everything alone
		write_reg(lfk_pkg::CFG_IDX_W'($urandom_range(4, 15)), 8'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// drive one triple; outside quiet mode the task itself sometimes drops valid afterward
	task automatic send_angles(input logic signed [lfk_pkg::ANG_IN_W-1:0] h, t, k,
			input bit known, input foot_pos_t want);
		foot_pos_t p;
		angle_valid <= 1'b1;
		hip_angle <= h;
		thigh_angle <= t;
		knee_angle <= k;
		@(negedge clk);
		while (!angle_ready)
			@(negedge clk);
		foot_position(h, t, k, p);
		if (known && (p.x !== want.x || p.y !== want.y || p.z !== want.z))
			report_mismatch("typed expectation", p.x, want.x);
		pending_pos.push_back(p);
		@(posedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			angle_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	function automatic logic signed [lfk_pkg::ANG_IN_W-1:0] rand_angle();
		case ($urandom_range(0, 3))
			0: return lfk_pkg::ANG_IN_W'($signed($urandom_range(0, 92160)) - 46080);
			1: return lfk_pkg::ANG_IN_W'($signed($urandom_range(0, 411774)) - 205887);
			default: return lfk_pkg::ANG_IN_W'($urandom);
		endcase
	endfunction

	vec_t dir_tab[$];
	foot_pos_t zero_pos = '{0, 0, 0};

	initial begin
		vec_t v;
		foot_pos_t none;
		none = zero_pos;
		dir_tab = '{
			'{11, 54, 72, 0, 0, 0, 0, 0, none},
			'{11, 54, 72, 0, 23040, 0, 0, 0, none},
			'{11, 54, 72, 0, -23040, 11520, -11520, 0, none},
			'{11, 54, 72, 0, 46080, 46080, 46080, 0, none},
			'{11, 54, 72, 0, MAX_ANG, MIN_ANG, MAX_ANG, 0, none},
			'{11, 54, 72, 0, MIN_ANG, MAX_ANG, MIN_ANG, 0, none},
			'{11, 54, 72, 0, -1, 1, -1, 0, none},
			'{0, 0, 0, 0, 12345, -6789, 30000, 1, zero_pos},
			'{0, 0, 0, 1, MAX_ANG, MIN_ANG, 0, 1, zero_pos},
			'{255, 255, 255, 1, 0, 0, 0, 0, none},
			'{255, 255, 255, 1, 102944, 102944, -102944, 0, none},
			'{255, 255, 255, 1, 205887, -205887, 205887, 0, none},
			'{255, 255, 255, 1, MAX_ANG, MAX_ANG, MAX_ANG, 0, none},
			'{255, 255, 255, 1, MIN_ANG, MIN_ANG, MIN_ANG, 0, none},
			'{255, 255, 0, 1, 0, 0, 0, 0, none},
			'{255, 255, 0, 0, 0, 23040, 0, 0, none},
			'{0, 255, 255, 0, 46080, 23040, 23040, 0, none},
			'{1, 1, 1, 0, 1, 1, 1, 0, none},
			'{128, 0, 255, 1, 51472, 154416, -51472, 0, none},
			'{128, 0, 255, 0, -46080, -46079, 46079, 0, none}
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i]) begin
			v = dir_tab[i];
			if (v.l1 != len_hip || v.l2 != len_thigh || v.l3 != len_shank
					|| v.units != units_rad) begin
				angle_valid <= 1'b0;
				set_links(v.l1, v.l2, v.l3, {7'($urandom), v.units});
			end
			send_angles(v.h, v.t, v.k, v.known, v.pos);
		end
		for (int ph = 0; ph < 6; ph++) begin
			angle_valid <= 1'b0;
			if (ph == 5)
				quiet = 1'b1;
			if (ph == 2)
				set_links(8'd255, 8'd255, 8'd255, 8'd255);
			else if (ph == 4)
				set_links(8'd0, 8'($urandom), 8'd0, 8'd0);
			else
				set_links(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			for (int n = 0; n < 225; n++) begin
				send_angles(rand_angle(), rand_angle(), rand_angle(), 1'b0, none);
				if (ph == 1 && n == 100) begin
					// hold the sender until the pipeline has fully drained
					angle_valid <= 1'b0;
					while (pending_pos.size() != 0)
						@(posedge clk);
				end
			end
		end
		angle_valid <= 1'b0;
		wait_drained();
		if (err_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
